>>> src/dttm_pkg.sv
// ----------------------------------------------------------------------------
// dttm_pkg
// Shared constants and the note-to-frequency function for the dual triangle
// tone mixer.
// ----------------------------------------------------------------------------
package dttm_pkg;

    localparam int unsigned SAMPLE_RATE_DEF = 44100;
    localparam int unsigned PHASE_BITS_DEF  = 32;

    localparam int unsigned KEY_W     = 7;
    localparam int unsigned KEY_COUNT = 1 << KEY_W;
    localparam int unsigned SAMPLE_W  = 16;

    localparam int unsigned KEYS_PER_OCTAVE = 12;
    localparam int          OCTAVE_BIAS     = 6;
    localparam int unsigned KEY_OFFSET      = 3;

    localparam logic [63:0] A4_HZ      = 64'd440;
    localparam logic [63:0] F16_SCALE  = 64'd65536;
    localparam logic [63:0] E10_SCALE  = 64'd10000000000;
    localparam logic [63:0] E10_HALF   = 64'd5000000000;

    // Twelfth roots of two, scaled by ten to the tenth.
    localparam logic [63:0] SEMITONE_E10 [KEYS_PER_OCTAVE] = '{
        64'd10000000000, 64'd10594630944, 64'd11224620483, 64'd11892071150,
        64'd12599210499, 64'd13348398542, 64'd14142135624, 64'd14983070769,
        64'd15874010520, 64'd16817928305, 64'd17817974363, 64'd18877486254
    };

    // Note frequency in Q16 Hz for a MIDI key; key zero gives zero.
    function automatic logic [63:0] key_f16(input int unsigned key);
        int unsigned u;
        int          oct;
        logic [63:0] f16;
        if (key == 0) begin
            return 64'd0;
        end
        u   = key + KEY_OFFSET;
        oct = int'(u / KEYS_PER_OCTAVE) - OCTAVE_BIAS;
        f16 = (A4_HZ * SEMITONE_E10[u % KEYS_PER_OCTAVE] * F16_SCALE + E10_HALF) / E10_SCALE;
        if (oct >= 0) begin
            f16 = f16 << oct;
        end else begin
            f16 = (f16 + (64'd1 << (-oct - 1))) >> (-oct);
        end
        return f16;
    endfunction

endpackage

>>> src/dttm_inc_rom.sv
// ----------------------------------------------------------------------------
// dttm_inc_rom
// Constant table of per-sample phase increments, one entry per MIDI key.
// ----------------------------------------------------------------------------
module dttm_inc_rom #(
    parameter int unsigned SAMPLE_RATE = dttm_pkg::SAMPLE_RATE_DEF,
    parameter int unsigned PHASE_BITS  = dttm_pkg::PHASE_BITS_DEF
) (
    input  logic [dttm_pkg::KEY_W-1:0] i_key,
    output logic [PHASE_BITS-1:0]      o_inc
);

    logic [PHASE_BITS-1:0] w_tab [dttm_pkg::KEY_COUNT];

    // Each entry is worked out at elaboration and rounded half up.
    for (genvar k = 0; k < dttm_pkg::KEY_COUNT; k++) begin : g_tab
        localparam logic [63:0] F16 = dttm_pkg::key_f16(k);
        localparam logic [63:0] NUM = F16 << (PHASE_BITS - 16);
        localparam logic [63:0] INC = (NUM + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
        assign w_tab[k] = INC[PHASE_BITS-1:0];
    end

    assign o_inc = w_tab[i_key];

endmodule

>>> src/dual_triangle_tone_mixer_unit.sv
// ----------------------------------------------------------------------------
// dual_triangle_tone_mixer_unit
// Two-voice triangle tone generator with dithered 16-bit output.
// ----------------------------------------------------------------------------
// One sample word is produced for every accepted key pair, and a new pair can
// be accepted on every clock cycle while the receiver does not stall. The
// input stage reads both phase accumulators and steps the dither LFSR. The
// second stage forms the two weighted triangle products. The third sums them
// and scales them to full range. The output register holds the dithered,
// rounded word. Each accepted key pair sets how far its voice's phase
// advances after the sample is taken; key zero holds that voice. The phase
// update, an increment table lookup and a PHASE_BITS-wide add, is the loop
// that sets the per-sample rate.
module dual_triangle_tone_mixer_unit #(
    parameter int unsigned SAMPLE_RATE = dttm_pkg::SAMPLE_RATE_DEF,
    parameter int unsigned PHASE_BITS  = dttm_pkg::PHASE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dttm_pkg::KEY_W-1:0]    i_melody_key,
    input  logic [dttm_pkg::KEY_W-1:0]    i_bass_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dttm_pkg::SAMPLE_W-1:0] o_sample_word
);

    localparam int unsigned TRI_W   = 32;
    localparam int unsigned WGT_W   = 16;
    localparam int unsigned PROD_W  = TRI_W + WGT_W;
    localparam int unsigned SCALE_W = 64;
    localparam int unsigned LFSR_W  = 16;

    localparam logic [WGT_W-1:0]      W_MELODY   = 16'd36045;
    localparam logic [WGT_W-1:0]      W_BASS     = 16'd29491;
    localparam logic [LFSR_W-1:0]     LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0]     LFSR_SEED  = 16'hACE1;
    localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [SCALE_W-1:0]    ROUND_HALF = 64'd1 << 47;
    localparam logic signed [SCALE_W-1:0] NEG_HALF = -(64'sd1 <<< 47);

    // Handshake enables, one per stage.
    logic w_en1, w_en2, w_en3, w_en_out, w_accept;

    logic r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;

    logic [PHASE_BITS-1:0] r_mel_phase, r_bass_phase, n_mel_phase, n_bass_phase;
    logic [PHASE_BITS-1:0] w_mel_inc, w_bass_inc;
    logic [LFSR_W-1:0]     r_lfsr, n_lfsr;

    logic [PHASE_BITS-1:0] w_mel_tri, w_bass_tri;
    logic [TRI_W-1:0]      w_mel_tri32, w_bass_tri32;

    logic [TRI_W-1:0]   r_s1_mel_tri, r_s1_bass_tri;
    logic [LFSR_W-1:0]  r_s1_lfsr;
    logic [PROD_W-1:0]  r_s2_mel_prod, r_s2_bass_prod;
    logic [LFSR_W-1:0]  r_s2_lfsr;
    logic [SCALE_W-1:0] r_s3_scaled;
    logic [LFSR_W-1:0]  r_s3_lfsr;

    logic [PROD_W-1:0]          w_mix;
    logic [SCALE_W-1:0]         n_scaled;
    logic [SCALE_W-1:0]         w_diff, w_rnd;
    logic [dttm_pkg::SAMPLE_W-1:0] n_sample, r_sample;

    assign w_en_out = !r_out_vld || i_ready;
    assign w_en3    = !r_s3_vld || w_en_out;
    assign w_en2    = !r_s2_vld || w_en3;
    assign w_en1    = !r_s1_vld || w_en2;
    assign o_ready  = w_en1;
    assign w_accept = i_valid && w_en1;

    dttm_inc_rom #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_mel_rom (
        .i_key (i_melody_key),
        .o_inc (w_mel_inc)
    );

    dttm_inc_rom #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_bass_rom (
        .i_key (i_bass_key),
        .o_inc (w_bass_inc)
    );

    always_comb begin
        n_mel_phase  = r_mel_phase + w_mel_inc;
        n_bass_phase = r_bass_phase + w_bass_inc;
        n_lfsr       = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
        w_mel_tri    = (r_mel_phase >= PHASE_HALF) ? (r_mel_phase - PHASE_HALF)
                                                   : (PHASE_HALF - r_mel_phase);
        w_bass_tri   = (r_bass_phase >= PHASE_HALF) ? (r_bass_phase - PHASE_HALF)
                                                    : (PHASE_HALF - r_bass_phase);
    end

    // Triangle magnitudes are brought to a common 32-bit fraction.
    if (PHASE_BITS > TRI_W) begin : g_tri_narrow
        assign w_mel_tri32  = w_mel_tri[PHASE_BITS-1 -: TRI_W];
        assign w_bass_tri32 = w_bass_tri[PHASE_BITS-1 -: TRI_W];
    end else begin : g_tri_wide
        assign w_mel_tri32  = TRI_W'(w_mel_tri) << (TRI_W - PHASE_BITS);
        assign w_bass_tri32 = TRI_W'(w_bass_tri) << (TRI_W - PHASE_BITS);
    end

    // Full-scale multiply by 65535 is a shift and a subtract.
    always_comb begin
        w_mix    = r_s2_mel_prod + r_s2_bass_prod;
        n_scaled = (SCALE_W'(w_mix) << 16) - SCALE_W'(w_mix);
    end

    // The result lies between -1 and half the 16-bit range, so a negative
    // difference rounds either to zero or to minus one.
    always_comb begin
        w_diff = r_s3_scaled - (SCALE_W'(r_s3_lfsr) << 32);
        w_rnd  = w_diff + ROUND_HALF;
        if (w_diff[SCALE_W-1]) begin
            n_sample = ($signed(w_diff) <= NEG_HALF) ? '1 : '0;
        end else begin
            n_sample = w_rnd[SCALE_W-1 -: dttm_pkg::SAMPLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mel_phase  <= '0;
            r_bass_phase <= '0;
            r_lfsr       <= LFSR_SEED;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mel_phase  <= n_mel_phase;
                r_bass_phase <= n_bass_phase;
                r_lfsr       <= n_lfsr;
            end
            if (w_en1) begin
                r_s1_vld <= i_valid;
            end
            if (w_en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_en_out) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mel_tri  <= w_mel_tri32;
            r_s1_bass_tri <= w_bass_tri32;
            r_s1_lfsr     <= n_lfsr;
        end
        if (w_en2 && r_s1_vld) begin
            r_s2_mel_prod  <= PROD_W'(r_s1_mel_tri) * PROD_W'(W_MELODY);
            r_s2_bass_prod <= PROD_W'(r_s1_bass_tri) * PROD_W'(W_BASS);
            r_s2_lfsr      <= r_s1_lfsr;
        end
        if (w_en3 && r_s2_vld) begin
            r_s3_scaled <= n_scaled;
            r_s3_lfsr   <= r_s2_lfsr;
        end
        if (w_en_out && r_s3_vld) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_sample_word = r_sample;

endmodule
